// ===== rtl/ratu_pkg.sv =====
package ratu_pkg;

    // Default datapath width and fixed field widths
    localparam int RATU_WIDTH = 32;
    localparam int FIELD_W    = 32;
    localparam int REQ_W      = 3;
    localparam int UA_W       = 5;

    typedef logic [UA_W-1:0] t_uaddr;

    // Request operation codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD = 3'd0,
        REQ_SUB = 3'd1,
        REQ_MUL = 3'd2,
        REQ_DIV = 3'd3,
        REQ_RED = 3'd4
    } t_req;

    // Micro-operations
    typedef enum logic [3:0] {
        UO_NOP,
        UO_MOV,
        UO_ZERO,
        UO_ADD,
        UO_SUB,
        UO_MUL,
        UO_DIVS,
        UO_DIVN,
        UO_GCD
    } t_uop;

    // Register file sources and destinations
    typedef enum logic [2:0] {
        SRC_AN, SRC_AD, SRC_BN, SRC_BD, SRC_RN, SRC_RD, SRC_T, SRC_G
    } t_src;

    typedef enum logic [2:0] {
        DST_RN, DST_RD, DST_T, DST_G, DST_Q
    } t_dst;

    // Sequencer branch conditions
    typedef enum logic [2:0] {
        CD_NEXT, CD_JUMP, CD_GZERO, CD_RDZERO, CD_END
    } t_cond;

    // Iterative unit operations
    typedef enum logic [1:0] {
        MOP_MUL, MOP_DIVS, MOP_DIVN, MOP_GCD
    } t_mop;

    typedef struct packed {
        t_uop   op;
        t_src   sa;
        t_src   sb;
        t_dst   dst;
        t_cond  cond;
        t_uaddr target;
    } t_cw;

    // Sequencer to datapath control
    typedef struct packed {
        logic load;
        logic go;
        t_uop op;
        t_src sa;
        t_src sb;
        t_dst dst;
    } t_ctl;

    // Datapath to sequencer status
    typedef struct packed {
        logic mdu_done;
        logic g_zero;
        logic rd_zero;
    } t_sts;

    // Program entry points
    localparam t_uaddr UA_ADD  = 5'd0;
    localparam t_uaddr UA_SUB  = 5'd4;
    localparam t_uaddr UA_MUL  = 5'd8;
    localparam t_uaddr UA_DIV  = 5'd10;
    localparam t_uaddr UA_RED  = 5'd12;
    localparam t_uaddr UA_ZERO = 5'd16;
    localparam t_uaddr UA_FIN  = 5'd18;
    localparam t_uaddr UA_END  = 5'd20;

    function automatic logic is_long(input t_uop op);
        logic r;
        r = (op == UO_MUL) || (op == UO_DIVS) || (op == UO_DIVN) || (op == UO_GCD);
        return r;
    endfunction

    function automatic t_cw mk(input t_uop op, input t_src sa, input t_src sb,
                               input t_dst dst, input t_cond cond, input t_uaddr tgt);
        t_cw w;
        w.op     = op;
        w.sa     = sa;
        w.sb     = sb;
        w.dst    = dst;
        w.cond   = cond;
        w.target = tgt;
        return w;
    endfunction

    // Control store
    function automatic t_cw ucode(input t_uaddr a);
        t_cw w;
        case (a)
            5'd0:  w = mk(UO_MUL,  SRC_AN, SRC_BD, DST_T,  CD_NEXT,   UA_END);
            5'd1:  w = mk(UO_MUL,  SRC_BN, SRC_AD, DST_RN, CD_NEXT,   UA_END);
            5'd2:  w = mk(UO_ADD,  SRC_T,  SRC_RN, DST_RN, CD_NEXT,   UA_END);
            5'd3:  w = mk(UO_MUL,  SRC_AD, SRC_BD, DST_RD, CD_JUMP,   UA_FIN);
            5'd4:  w = mk(UO_MUL,  SRC_AN, SRC_BD, DST_T,  CD_NEXT,   UA_END);
            5'd5:  w = mk(UO_MUL,  SRC_BN, SRC_AD, DST_RN, CD_NEXT,   UA_END);
            5'd6:  w = mk(UO_SUB,  SRC_T,  SRC_RN, DST_RN, CD_NEXT,   UA_END);
            5'd7:  w = mk(UO_MUL,  SRC_AD, SRC_BD, DST_RD, CD_JUMP,   UA_FIN);
            5'd8:  w = mk(UO_MUL,  SRC_AN, SRC_BN, DST_RN, CD_NEXT,   UA_END);
            5'd9:  w = mk(UO_MUL,  SRC_AD, SRC_BD, DST_RD, CD_JUMP,   UA_FIN);
            5'd10: w = mk(UO_MUL,  SRC_AN, SRC_BD, DST_RN, CD_NEXT,   UA_END);
            5'd11: w = mk(UO_MUL,  SRC_AD, SRC_BN, DST_RD, CD_JUMP,   UA_FIN);
            5'd12: w = mk(UO_GCD,  SRC_AN, SRC_AD, DST_G,  CD_NEXT,   UA_END);
            5'd13: w = mk(UO_NOP,  SRC_AN, SRC_AN, DST_T,  CD_GZERO,  UA_ZERO);
            5'd14: w = mk(UO_DIVN, SRC_AN, SRC_G,  DST_RN, CD_NEXT,   UA_END);
            5'd15: w = mk(UO_DIVN, SRC_AD, SRC_G,  DST_RD, CD_JUMP,   UA_FIN);
            5'd16: w = mk(UO_ZERO, SRC_AN, SRC_AN, DST_RN, CD_NEXT,   UA_END);
            5'd17: w = mk(UO_ZERO, SRC_AN, SRC_AN, DST_RD, CD_JUMP,   UA_END);
            5'd18: w = mk(UO_NOP,  SRC_AN, SRC_AN, DST_T,  CD_RDZERO, UA_END);
            5'd19: w = mk(UO_DIVS, SRC_RN, SRC_RD, DST_Q,  CD_NEXT,   UA_END);
            default: w = mk(UO_NOP, SRC_AN, SRC_AN, DST_T, CD_END,    UA_END);
        endcase
        return w;
    endfunction

    // Dispatch table
    function automatic t_uaddr entry(input logic [REQ_W-1:0] req);
        t_uaddr e;
        case (req)
            REQ_ADD: e = UA_ADD;
            REQ_SUB: e = UA_SUB;
            REQ_MUL: e = UA_MUL;
            REQ_DIV: e = UA_DIV;
            REQ_RED: e = UA_RED;
            default: e = UA_ZERO;
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/ratu_if.sv =====
interface ratu_req_if;
    import ratu_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic signed [FIELD_W-1:0] a_num;
    logic signed [FIELD_W-1:0] a_den;
    logic signed [FIELD_W-1:0] b_num;
    logic signed [FIELD_W-1:0] b_den;

    modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface ratu_res_if;
    import ratu_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] res_num;
    logic signed [FIELD_W-1:0] res_den;
    logic signed [FIELD_W-1:0] quotient;
    logic                      div_error;

    modport source (output valid, res_num, res_den, quotient, div_error, input ready);
    modport sink   (input valid, res_num, res_den, quotient, div_error, output ready);
endinterface

// ===== rtl/ratu_mdu.sv =====
module ratu_mdu
    import ratu_pkg::*;
#(
    parameter int WIDTH = RATU_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_mop             i_op,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic             o_done,
    output logic [WIDTH-1:0] o_res
);

    localparam int CNT_W = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    t_mop             r_op;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;
    logic [WIDTH-1:0] r_z;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_k;
    logic             r_neg;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   rem_diff;

    function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
        logic [WIDTH-1:0] m;
        m = v[WIDTH-1] ? (~v + 1'b1) : v;
        return m;
    endfunction

    // Restoring division step: shift in next dividend bit, trial subtract
    always_comb begin
        rem_sh   = {r_x, r_y[WIDTH-1]};
        rem_diff = rem_sh - {1'b0, r_z};
    end

    // Iterate one bit or one gcd step per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_op   <= i_op;
                r_cnt  <= CNT_W'(WIDTH - 1);
                r_k    <= '0;
                case (i_op)
                    MOP_MUL: begin
                        r_x <= '0;
                        r_y <= i_a;
                        r_z <= i_b;
                    end
                    MOP_DIVS: begin
                        r_x   <= '0;
                        r_y   <= mag(i_a);
                        r_z   <= mag(i_b);
                        r_neg <= i_a[WIDTH-1] ^ i_b[WIDTH-1];
                    end
                    MOP_DIVN: begin
                        r_x   <= '0;
                        r_y   <= mag(i_a);
                        r_z   <= i_b;
                        r_neg <= i_a[WIDTH-1];
                    end
                    default: begin
                        r_x <= mag(i_a);
                        r_z <= mag(i_b);
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    MOP_MUL: begin
                        if (r_z[0]) begin
                            r_x <= r_x + r_y;
                        end
                        r_y   <= r_y << 1;
                        r_z   <= r_z >> 1;
                        r_cnt <= r_cnt - 1'b1;
                        if (r_cnt == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    MOP_DIVS, MOP_DIVN: begin
                        if (!rem_diff[WIDTH]) begin
                            r_x <= rem_diff[WIDTH-1:0];
                            r_y <= {r_y[WIDTH-2:0], 1'b1};
                        end else begin
                            r_x <= rem_sh[WIDTH-1:0];
                            r_y <= {r_y[WIDTH-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 1'b1;
                        if (r_cnt == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    default: begin
                        if (r_x == '0 || r_z == '0) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end else if (!r_x[0] && !r_z[0]) begin
                            r_x <= r_x >> 1;
                            r_z <= r_z >> 1;
                            r_k <= r_k + 1'b1;
                        end else if (!r_x[0]) begin
                            r_x <= r_x >> 1;
                        end else if (!r_z[0]) begin
                            r_z <= r_z >> 1;
                        end else if (r_x >= r_z) begin
                            r_x <= r_x - r_z;
                        end else begin
                            r_z <= r_z - r_x;
                        end
                    end
                endcase
            end
        end
    end

    // Select the finished result
    always_comb begin
        case (r_op)
            MOP_MUL:           o_res = r_x;
            MOP_DIVS, MOP_DIVN: o_res = r_neg ? (~r_y + 1'b1) : r_y;
            default:           o_res = (r_x | r_z) << r_k;
        endcase
    end

    assign o_done = r_done;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a running operation");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (!r_busy && !r_done))
        else $error("start while unit occupied");

    a_count_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_op != MOP_GCD && r_cnt == '0) |=> (r_done && !r_busy))
        else $error("multiply or divide did not finish on last step");
`endif

endmodule

// ===== rtl/ratu_dpath.sv =====
module ratu_dpath
    import ratu_pkg::*;
#(
    parameter int WIDTH = RATU_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctl                      i_ctl,
    input  logic signed [FIELD_W-1:0] i_a_num,
    input  logic signed [FIELD_W-1:0] i_a_den,
    input  logic signed [FIELD_W-1:0] i_b_num,
    input  logic signed [FIELD_W-1:0] i_b_den,
    output t_sts                      o_sts,
    output logic [WIDTH-1:0]          o_rn,
    output logic [WIDTH-1:0]          o_rd,
    output logic [WIDTH-1:0]          o_q
);

    logic [WIDTH-1:0] r_an;
    logic [WIDTH-1:0] r_ad;
    logic [WIDTH-1:0] r_bn;
    logic [WIDTH-1:0] r_bd;
    logic [WIDTH-1:0] r_rn;
    logic [WIDTH-1:0] r_rd;
    logic [WIDTH-1:0] r_t;
    logic [WIDTH-1:0] r_g;
    logic [WIDTH-1:0] r_q;

    logic [WIDTH-1:0] opa;
    logic [WIDTH-1:0] opb;
    logic [WIDTH-1:0] alu;
    logic [WIDTH-1:0] wr_val;
    logic             wr_en;
    logic             mdu_start;
    logic             mdu_done;
    logic [WIDTH-1:0] mdu_res;
    t_mop             mop;

    // Source operand select
    always_comb begin
        case (i_ctl.sa)
            SRC_AN:  opa = r_an;
            SRC_AD:  opa = r_ad;
            SRC_BN:  opa = r_bn;
            SRC_BD:  opa = r_bd;
            SRC_RN:  opa = r_rn;
            SRC_RD:  opa = r_rd;
            SRC_T:   opa = r_t;
            default: opa = r_g;
        endcase
        case (i_ctl.sb)
            SRC_AN:  opb = r_an;
            SRC_AD:  opb = r_ad;
            SRC_BN:  opb = r_bn;
            SRC_BD:  opb = r_bd;
            SRC_RN:  opb = r_rn;
            SRC_RD:  opb = r_rd;
            SRC_T:   opb = r_t;
            default: opb = r_g;
        endcase
    end

    // Combinational ALU operations and iterative unit dispatch
    always_comb begin
        case (i_ctl.op)
            UO_MOV:  alu = opa;
            UO_ADD:  alu = opa + opb;
            UO_SUB:  alu = opa - opb;
            default: alu = '0;
        endcase
        case (i_ctl.op)
            UO_MUL:  mop = MOP_MUL;
            UO_DIVS: mop = MOP_DIVS;
            UO_DIVN: mop = MOP_DIVN;
            default: mop = MOP_GCD;
        endcase
        mdu_start = i_ctl.go && is_long(i_ctl.op);
        wr_en     = (i_ctl.go && !is_long(i_ctl.op) && i_ctl.op != UO_NOP) || mdu_done;
        wr_val    = mdu_done ? mdu_res : alu;
    end

    ratu_mdu #(
        .WIDTH (WIDTH)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mdu_start),
        .i_op    (mop),
        .i_a     (opa),
        .i_b     (opb),
        .o_done  (mdu_done),
        .o_res   (mdu_res)
    );

    // Load operands at WIDTH bits, write back results
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_an <= WIDTH'(i_a_num);
            r_ad <= WIDTH'(i_a_den);
            r_bn <= WIDTH'(i_b_num);
            r_bd <= WIDTH'(i_b_den);
        end else if (wr_en) begin
            case (i_ctl.dst)
                DST_RN:  r_rn <= wr_val;
                DST_RD:  r_rd <= wr_val;
                DST_T:   r_t  <= wr_val;
                DST_G:   r_g  <= wr_val;
                default: r_q  <= wr_val;
            endcase
        end
    end

    assign o_sts.mdu_done = mdu_done;
    assign o_sts.g_zero   = (r_g == '0);
    assign o_sts.rd_zero  = (r_rd == '0);
    assign o_rn = r_rn;
    assign o_rd = r_rd;
    assign o_q  = r_q;

endmodule

// ===== rtl/ratu_useq.sv =====
module ratu_useq
    import ratu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [REQ_W-1:0] i_req_type,
    input  logic             i_out_free,
    input  t_sts             i_sts,
    output t_ctl             o_ctl,
    output logic             o_idle,
    output logic             o_finish
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state r_state, n_state;
    t_uaddr r_pc, n_pc;
    logic   r_wait, n_wait;

    t_cw    cw;
    logic   long_op;
    logic   at_end;
    logic   run;
    logic   go;
    logic   step_done;
    logic   taken;
    logic   finish;

    // Fetch, branch and step control
    always_comb begin
        cw        = ucode(r_pc);
        long_op   = is_long(cw.op);
        at_end    = (cw.cond == CD_END);
        run       = (r_state == S_RUN);
        go        = run && !r_wait && !at_end;
        step_done = long_op ? (r_wait && i_sts.mdu_done) : go;
        finish    = run && at_end && i_out_free;
        case (cw.cond)
            CD_JUMP:   taken = 1'b1;
            CD_GZERO:  taken = i_sts.g_zero;
            CD_RDZERO: taken = i_sts.rd_zero;
            default:   taken = 1'b0;
        endcase

        n_state = r_state;
        n_pc    = r_pc;
        n_wait  = r_wait;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_pc    = entry(i_req_type);
                    n_wait  = 1'b0;
                end
            end
            S_RUN: begin
                if (finish) begin
                    n_state = S_IDLE;
                end else begin
                    if (go && long_op) begin
                        n_wait = 1'b1;
                    end
                    if (step_done) begin
                        n_wait = 1'b0;
                        n_pc   = taken ? cw.target : t_uaddr'(r_pc + 1'b1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= UA_END;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_wait  <= n_wait;
        end
    end

    assign o_ctl.load = (r_state == S_IDLE) && i_start;
    assign o_ctl.go   = go;
    assign o_ctl.op   = cw.op;
    assign o_ctl.sa   = cw.sa;
    assign o_ctl.sb   = cw.sb;
    assign o_ctl.dst  = cw.dst;
    assign o_idle     = (r_state == S_IDLE);
    assign o_finish   = finish;

`ifndef SYNTHESIS
    a_pc_holds_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wait && !i_sts.mdu_done) |=> (r_pc == $past(r_pc)))
        else $error("step advanced while iterative unit still running");
`endif

endmodule

// ===== rtl/rational_arith_unit_core.sv =====
// Throughput: one item at a time; the next item is taken the cycle after a result
// enters the output register. Each product, quotient and gcd runs on one shared
// iterative unit, one bit or one gcd step per cycle.
// Reset: synchronous active low; clears sequencer, iterative unit and handshake state.
module rational_arith_unit_core
    import ratu_pkg::*;
#(
    parameter int WIDTH = RATU_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ratu_req_if.sink   i_req,
    ratu_res_if.source o_res
);

    t_ctl             ctl;
    t_sts             sts;
    logic             idle;
    logic             finish;
    logic             accept;
    logic             out_free;
    logic [WIDTH-1:0] rn;
    logic [WIDTH-1:0] rd;
    logic [WIDTH-1:0] q;
    logic             err;

    logic               r_out_vld;
    logic [FIELD_W-1:0] r_o_num;
    logic [FIELD_W-1:0] r_o_den;
    logic [FIELD_W-1:0] r_o_quo;
    logic               r_o_err;

    assign accept   = i_req.valid && idle;
    assign out_free = !r_out_vld || o_res.ready;
    assign err      = (rd == '0);

    ratu_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_req_type (i_req.req_type),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_idle     (idle),
        .o_finish   (finish)
    );

    ratu_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_a_num (i_req.a_num),
        .i_a_den (i_req.a_den),
        .i_b_num (i_req.b_num),
        .i_b_den (i_req.b_den),
        .o_sts   (sts),
        .o_rn    (rn),
        .o_rd    (rd),
        .o_q     (q)
    );

    // Hold the finished item until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (finish) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_o_num <= FIELD_W'(rn);
            r_o_den <= FIELD_W'(rd);
            r_o_quo <= err ? '0 : FIELD_W'(q);
            r_o_err <= err;
        end
    end

    assign i_req.ready     = idle;
    assign o_res.valid     = r_out_vld;
    assign o_res.res_num   = r_o_num;
    assign o_res.res_den   = r_o_den;
    assign o_res.quotient  = r_o_quo;
    assign o_res.div_error = r_o_err;

endmodule

// ===== tb/rational_arith_unit_core_test.sv =====
module rational_arith_unit_core_test;
    import ratu_pkg::*;

    localparam int WIDTH        = RATU_WIDTH;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int LONG_STALL   = 600;
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_ITEMS = 1020;
    localparam int STEADY_ITEMS = 200;

    // Operation codes the block does not define
    localparam logic [REQ_W-1:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [REQ_W-1:0] OP_UNUSED_MID = 3'd6;
    localparam logic [REQ_W-1:0] OP_UNUSED_HI  = 3'd7;

    localparam logic signed [FIELD_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

    typedef bit [WIDTH-1:0] t_word;

    typedef struct {
        logic [REQ_W-1:0]          req_type;
        logic signed [FIELD_W-1:0] a_num;
        logic signed [FIELD_W-1:0] a_den;
        logic signed [FIELD_W-1:0] b_num;
        logic signed [FIELD_W-1:0] b_den;
    } t_frac_req;

    typedef struct {
        logic signed [FIELD_W-1:0] res_num;
        logic signed [FIELD_W-1:0] res_den;
        logic signed [FIELD_W-1:0] quotient;
        logic                      div_error;
    } t_frac_res;

    typedef enum {RX_OPEN, RX_CHOPPY, RX_RANDOM} t_rx_mode;

    logic clk;
    logic rst_n;

    ratu_req_if req_bus ();
    ratu_res_if res_bus ();

    rational_arith_unit_core #(.WIDTH(WIDTH)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    t_frac_res due_fractions[$];
    int        failures     = 0;
    int        results_seen = 0;
    int        items_sent   = 0;
    int        op_count [0:7];
    int        cycle_count  = 0;

    // Sender pacing, owned by the stimulus process
    bit        sender_bursty = 1'b1;
    int        burst_left    = 0;

    // Receiver controls: mode and stall requests are written by the stimulus, read at the clock edge
    t_rx_mode  rx_mode    = RX_OPEN;
    int        stall_asks = 0;
    int        stall_seen = 0;
    int        stall_left = 0;
    int        rx_phase   = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sign-extend a field, then cut it to the datapath width
    function automatic t_word to_word(input logic signed [FIELD_W-1:0] x);
        logic signed [63:0] ext;
        ext = x;
        return ext[WIDTH-1:0];
    endfunction

    function automatic t_word magnitude(input t_word x);
        return x[WIDTH-1] ? -x : x;
    endfunction

    // Compute the unreduced fraction (reduced first fraction, zero for unused codes) and its quotient
    function automatic t_frac_res predict_fraction(input t_frac_req r);
        t_word     an, ad, bn, bd, rn, rd, x, y, t, q;
        t_frac_res p;
        an = to_word(r.a_num);
        ad = to_word(r.a_den);
        bn = to_word(r.b_num);
        bd = to_word(r.b_den);
        rn = '0;
        rd = '0;
        case (r.req_type)
            REQ_ADD: begin
                rn = an * bd + bn * ad;
                rd = ad * bd;
            end
            REQ_SUB: begin
                rn = an * bd - bn * ad;
                rd = ad * bd;
            end
            REQ_MUL: begin
                rn = an * bn;
                rd = ad * bd;
            end
            REQ_DIV: begin
                rn = an * bd;
                rd = ad * bn;
            end
            REQ_RED: begin
                rn = an;
                rd = ad;
                x  = magnitude(an);
                y  = magnitude(ad);
                while (y != 0) begin
                    t = x % y;
                    x = y;
                    y = t;
                end
                // x now holds the gcd; zero leaves the fraction untouched
                if (x != 0) begin
                    rn = magnitude(an) / x;
                    rd = magnitude(ad) / x;
                    if (an[WIDTH-1]) rn = -rn;
                    if (ad[WIDTH-1]) rd = -rd;
                end
            end
            default: ;
        endcase
        p.res_num = rn;
        p.res_den = rd;
        if (rd == 0) begin
            p.quotient  = '0;
            p.div_error = 1'b1;
        end else begin
            q = magnitude(rn) / magnitude(rd);
            if (rn[WIDTH-1] != rd[WIDTH-1]) q = -q;
            p.quotient  = q;
            p.div_error = 1'b0;
        end
        return p;
    endfunction

    function automatic t_frac_req make_request(input logic [REQ_W-1:0] op,
                                               input logic signed [FIELD_W-1:0] an, ad,
                                               input logic signed [FIELD_W-1:0] bn, bd);
        t_frac_req r;
        r.req_type = op;
        r.a_num    = an;
        r.a_den    = ad;
        r.b_num    = bn;
        r.b_den    = bd;
        return r;
    endfunction

    // Mix full-range words with small, extreme and single-bit values
    function automatic logic signed [FIELD_W-1:0] random_operand();
        logic signed [FIELD_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom;
            3, 4:    v = int'($urandom_range(0, 40)) - 20;
            5:       v = int'($urandom_range(0, 2000)) - 1000;
            6: begin
                v = FIELD_W'(1) << $urandom_range(0, FIELD_W-1);
                if ($urandom_range(0, 1)) v = -v;
            end
            7: begin
                case ($urandom_range(0, 4))
                    0:       v = MOST_NEG;
                    1:       v = MOST_POS;
                    2:       v = '0;
                    3:       v = 1;
                    default: v = -1;
                endcase
            end
            default: v = int'($urandom_range(0, 131070)) - 65535;
        endcase
        return v;
    endfunction

    function automatic t_frac_req random_request();
        t_frac_req r;
        int        factor;
        if ($urandom_range(0, 31) == 0)
            r.req_type = REQ_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        else
            r.req_type = REQ_W'($urandom_range(REQ_RED, REQ_ADD));
        r.a_num = random_operand();
        r.a_den = random_operand();
        r.b_num = random_operand();
        r.b_den = random_operand();
        // Give most reductions a shared factor so the gcd is nontrivial
        if (r.req_type == REQ_RED && $urandom_range(0, 3) != 0) begin
            factor  = $urandom_range(1, 5000);
            r.a_num = (int'($urandom_range(0, 200)) - 100) * factor;
            r.a_den = (int'($urandom_range(0, 200)) - 100) * factor;
        end
        return r;
    endfunction

    // Offer one item, hold it until accepted, then queue its prediction
    task automatic send_item(input t_frac_req r);
        int gap;
        if (sender_bursty && burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0) burst_left--;
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= r.req_type;
        req_bus.a_num    <= r.a_num;
        req_bus.a_den    <= r.a_den;
        req_bus.b_num    <= r.b_num;
        req_bus.b_den    <= r.b_den;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
        due_fractions.push_back(predict_fraction(r));
        items_sent++;
        op_count[r.req_type]++;
    endtask

    task automatic test_basic_ops();
        send_item(make_request(REQ_ADD, 1, 2, 1, 3));
        send_item(make_request(REQ_SUB, 1, 2, 1, 3));
        send_item(make_request(REQ_MUL, -3, 4, 2, 5));
        send_item(make_request(REQ_DIV, 3, 4, -2, 5));
        send_item(make_request(REQ_RED, 12, -18, 7, 9));
    endtask

    task automatic test_zero_denominators();
        send_item(make_request(REQ_ADD, 3, 0, 1, 2));
        send_item(make_request(REQ_DIV, 5, 7, 0, 3));
        send_item(make_request(REQ_MUL, -4, 9, 2, 0));
        send_item(make_request(REQ_RED, 0, 0, 1, 1));
        send_item(make_request(REQ_RED, 0, -7, 1, 1));
        send_item(make_request(REQ_RED, 5, 0, 1, 1));
    endtask

    task automatic test_wraparound();
        send_item(make_request(REQ_MUL, MOST_POS, 1, MOST_POS, 1));
        send_item(make_request(REQ_ADD, MOST_POS, 1, 1, 1));
        send_item(make_request(REQ_SUB, MOST_NEG, 1, 1, 1));
        // Most negative over minus one overflows the quotient
        send_item(make_request(REQ_MUL, MOST_NEG, -1, 1, 1));
        send_item(make_request(REQ_RED, MOST_NEG, MOST_NEG, 0, 0));
        send_item(make_request(REQ_RED, MOST_NEG, 6, -1, -1));
        send_item(make_request(REQ_DIV, MOST_NEG, MOST_POS, MOST_POS, MOST_NEG));
        send_item(make_request(REQ_SUB, -1, -1, -1, -1));
    endtask

    task automatic test_unused_codes();
        send_item(make_request(OP_UNUSED_LO, 6, 3, 2, 1));
        send_item(make_request(OP_UNUSED_MID, MOST_NEG, MOST_POS, -1, 0));
        send_item(make_request(OP_UNUSED_HI, -1, -1, -1, -1));
    endtask

    // Bursty sender against a receiver that changes its stall style
    task automatic test_random_traffic();
        int n;
        sender_bursty = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 250 == 0) rx_mode <= (n % 500 == 0) ? RX_CHOPPY : RX_RANDOM;
            send_item(random_request());
        end
    endtask

    // No idling on either side
    task automatic test_steady_stream();
        int n;
        sender_bursty = 1'b0;
        rx_mode <= RX_OPEN;
        for (n = 0; n < STEADY_ITEMS; n++) send_item(random_request());
    endtask

    // Hold the output off long enough for the block to refuse input
    task automatic test_output_holdoff();
        int n;
        sender_bursty = 1'b0;
        rx_mode    <= RX_OPEN;
        stall_asks <= stall_asks + 1;
        for (n = 0; n < 8; n++) send_item(random_request());
        rx_mode <= RX_CHOPPY;
    endtask

    // Check each result against the oldest prediction; drive ready
    always @(posedge clk) begin
        t_frac_res want;
        if (rst_n && res_bus.valid && res_bus.ready) begin
            if (due_fractions.size() == 0) begin
                $error("result with no request pending: %0d/%0d",
                       res_bus.res_num, res_bus.res_den);
                failures++;
            end else begin
                want = due_fractions.pop_front();
                results_seen++;
                if (res_bus.res_num !== want.res_num) begin
                    $error("res_num: expected %0d, got %0d", want.res_num, res_bus.res_num);
                    failures++;
                end
                if (res_bus.res_den !== want.res_den) begin
                    $error("res_den: expected %0d, got %0d", want.res_den, res_bus.res_den);
                    failures++;
                end
                if (res_bus.quotient !== want.quotient) begin
                    $error("quotient: expected %0d, got %0d",
                           want.quotient, res_bus.quotient);
                    failures++;
                end
                if (res_bus.div_error !== want.div_error) begin
                    $error("div_error: expected %0b, got %0b",
                           want.div_error, res_bus.div_error);
                    failures++;
                end
            end
        end
        if (stall_asks != stall_seen) begin
            stall_seen = stall_asks;
            stall_left = LONG_STALL;
        end
        rx_phase = (rx_phase + 1) % 11;
        if (stall_left > 0) begin
            stall_left--;
            res_bus.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:   res_bus.ready <= 1'b1;
                RX_CHOPPY: res_bus.ready <= !(rx_phase == 3 || rx_phase == 4 || rx_phase == 8);
                default:   res_bus.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Bound the run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 8; i++) op_count[i] = 0;
        rst_n            = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.req_type = '0;
        req_bus.a_num    = '0;
        req_bus.a_den    = '0;
        req_bus.b_num    = '0;
        req_bus.b_den    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_zero_denominators();
        test_wraparound();
        test_unused_codes();
        test_random_traffic();
        test_output_holdoff();
        test_steady_stream();

        // Drain outstanding results, then watch for strays
        req_bus.valid <= 1'b0;
        rx_mode       <= RX_OPEN;
        while (due_fractions.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items (add %0d, sub %0d, mul %0d, div %0d, reduce %0d, other %0d)",
                 items_sent, op_count[REQ_ADD], op_count[REQ_SUB], op_count[REQ_MUL],
                 op_count[REQ_DIV], op_count[REQ_RED],
                 op_count[OP_UNUSED_LO] + op_count[OP_UNUSED_MID] + op_count[OP_UNUSED_HI]);
        $display("Checked %0d results under bursty, steady and %0d-cycle held-off output",
                 results_seen, LONG_STALL);
        if (failures == 0 && due_fractions.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
